// File: rtl/mfs_pkg.sv
package mfs_pkg;

    localparam int unsigned HANDLE_W  = 16;
    localparam int unsigned QVOL_W    = 17;
    localparam int unsigned FADE_W    = 21;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned STEP_W    = FADE_W + ELAPSED_W;
    localparam int unsigned ENGVOL_W  = 8;
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned PADDR_W   = 4;

    localparam logic [FADE_W-1:0] Q20_ONE = 21'd1048576;
    localparam logic [QVOL_W-1:0] Q16_ONE = 17'd65536;

    localparam logic [FADE_W-1:0] FADE_RATE_RST   = 21'd1049;
    localparam logic [QVOL_W-1:0] MUSIC_GAIN_RST  = 17'd65536;
    localparam logic [QVOL_W-1:0] EFFECT_GAIN_RST = 17'd65536;

    localparam logic [1:0] REG_FADE_RATE   = 2'd0;
    localparam logic [1:0] REG_MUSIC_GAIN  = 2'd1;
    localparam logic [1:0] REG_EFFECT_GAIN = 2'd2;

    typedef enum logic [1:0] {
        MODE_PLAY   = 2'd0,
        MODE_STOP   = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_EFFECT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_SETVOL = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_LOOP   = 2'd2,
        CMD_ONCE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_IN   = 2'd1,
        PH_OUT  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_PEND_OUT,
        ST_LOAD,
        ST_STOP_FADE,
        ST_STOP_NOW,
        ST_TICK,
        ST_END,
        ST_SWAP
    } st_op_t;

    typedef struct packed {
        logic   latch;
        st_op_t st_op;
        logic   vol_start;
        logic   emit;
        cmd_t   emit_cmd;
        logic   emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        mode_t  mode;
        logic   cur_valid;
        logic   pend_valid;
        logic   same_track;
        phase_t phase;
        logic   use_fade;
        logic   fade_req;
        logic   tick_end;
        logic   vol_done;
        logic   out_free;
    } dp_stat_t;

endpackage

// File: rtl/mfs_vol.sv
module mfs_vol #(
    parameter int unsigned VOLUME_FULL = 255
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [mfs_pkg::FADE_W-1:0]         fade,
    input  logic [mfs_pkg::QVOL_W-1:0]         vol,
    input  logic [mfs_pkg::QVOL_W-1:0]         gain,
    output logic                               done,
    output logic [mfs_pkg::ENGVOL_W-1:0]       result
);

    localparam int unsigned VF_W  = $clog2(VOLUME_FULL + 1);
    localparam logic [VF_W-1:0] VF = VF_W'(VOLUME_FULL);
    localparam int unsigned P1_W  = 2 * mfs_pkg::QVOL_W - 1;
    localparam int unsigned Q_W   = 53;
    localparam int unsigned HALF  = 26;
    localparam int unsigned HI_W  = (Q_W - HALF) + VF_W;
    localparam int unsigned LO_W  = HALF + VF_W;
    localparam int unsigned SUM_W = HI_W + 1;
    localparam int unsigned R_W   = SUM_W - HALF;
    localparam int unsigned RX_W  = (R_W > mfs_pkg::ENGVOL_W) ? R_W : mfs_pkg::ENGVOL_W;

    logic [3:0]                      v_reg, v_next;
    logic [P1_W-1:0]                 p1_reg;
    logic [mfs_pkg::FADE_W-1:0]      fs_reg;
    logic [Q_W-1:0]                  q_reg;
    logic [HI_W-1:0]                 hi_reg;
    logic [VF_W-1:0]                 lo_reg;
    logic [mfs_pkg::ENGVOL_W-1:0]    res_reg, res_next;

    logic [mfs_pkg::FADE_W-1:0]      fade_s;
    logic [mfs_pkg::QVOL_W-1:0]      vol_s, gain_s;
    logic [P1_W:0]                   p1_full;
    logic [Q_W:0]                    q_full;
    logic [HI_W-1:0]                 hi_next;
    logic [LO_W-1:0]                 lo_full;
    logic [SUM_W-1:0]                sum;
    logic [RX_W-1:0]                 r_x;

    // clamp every factor at unity before the product chain
    always_comb begin
        fade_s  = (fade > mfs_pkg::Q20_ONE) ? mfs_pkg::Q20_ONE : fade;
        vol_s   = (vol > mfs_pkg::Q16_ONE) ? mfs_pkg::Q16_ONE : vol;
        gain_s  = (gain > mfs_pkg::Q16_ONE) ? mfs_pkg::Q16_ONE : gain;
        p1_full = vol_s * gain_s;
        q_full  = p1_reg * fs_reg;
        // split the Q52 product so each scale multiply stays narrow
        hi_next = q_reg[Q_W-1:HALF] * VF;
        lo_full = q_reg[HALF-1:0] * VF;
        sum     = {1'b0, hi_reg} + SUM_W'(lo_reg);
        r_x     = RX_W'(sum[SUM_W-1:HALF]);
        res_next = (r_x > RX_W'(255)) ? 8'd255 : r_x[mfs_pkg::ENGVOL_W-1:0];
        v_next  = {v_reg[2:0], start};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            p1_reg <= p1_full[P1_W-1:0];
            fs_reg <= fade_s;
        end
        if (v_reg[0]) begin
            q_reg <= q_full[Q_W-1:0];
        end
        if (v_reg[1]) begin
            hi_reg <= hi_next;
            lo_reg <= lo_full[LO_W-1:HALF];
        end
        if (v_reg[2]) begin
            res_reg <= res_next;
        end
    end

    assign done   = v_reg[3];
    assign result = res_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(v_reg))
        else $error("volume chain holds more than one request");

endmodule

// File: rtl/mfs_dp.sv
module mfs_dp #(
    parameter int unsigned VOLUME_FULL = 255
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mfs_pkg::ctl_cmd_t                 cmd,
    output mfs_pkg::dp_stat_t                 stat,
    input  logic [mfs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [1:0]                        s_axis_tuser,
    input  logic [mfs_pkg::FADE_W-1:0]        fade_rate,
    input  logic [mfs_pkg::QVOL_W-1:0]        music_gain,
    input  logic [mfs_pkg::QVOL_W-1:0]        effect_gain,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mfs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int unsigned LV_W = mfs_pkg::STEP_W + 1;

    // latched request
    mfs_pkg::mode_t                    in_mode_reg;
    logic [mfs_pkg::HANDLE_W-1:0]      in_handle_reg;
    logic [mfs_pkg::QVOL_W-1:0]        in_vol_reg;
    logic                              in_fade_req_reg;
    logic                              in_allows_reg;
    logic [mfs_pkg::STEP_W-1:0]        step_reg;
    logic [mfs_pkg::STEP_W-1:0]        step_next;

    // playback state
    logic                              cur_valid_reg, cur_valid_next;
    logic [mfs_pkg::HANDLE_W-1:0]      cur_track_reg, cur_track_next;
    logic [mfs_pkg::QVOL_W-1:0]        cur_vol_reg, cur_vol_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [mfs_pkg::HANDLE_W-1:0]      pend_track_reg, pend_track_next;
    logic [mfs_pkg::QVOL_W-1:0]        pend_vol_reg, pend_vol_next;
    logic [mfs_pkg::FADE_W-1:0]        fade_reg, fade_next;
    mfs_pkg::phase_t                   phase_reg, phase_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    mfs_pkg::cmd_t                     out_cmd_reg;
    logic [mfs_pkg::HANDLE_W-1:0]      out_handle_reg;
    logic [mfs_pkg::ENGVOL_W-1:0]      out_volume_reg;
    logic                              out_last_reg;

    logic                              use_fade, tick_end, is_fx, out_free;
    logic [LV_W-1:0]                   lv;
    logic [mfs_pkg::FADE_W-1:0]        vsel_fade;
    logic [mfs_pkg::QVOL_W-1:0]        vsel_vol, vsel_gain;
    logic                              vol_done;
    logic [mfs_pkg::ENGVOL_W-1:0]      vol_result;
    logic [mfs_pkg::HANDLE_W-1:0]      emit_handle;

    assign step_next = fade_rate * s_axis_tdata[50:35];
    assign use_fade  = in_fade_req_reg & in_allows_reg;
    assign tick_end  = step_reg >= mfs_pkg::STEP_W'(fade_reg);
    assign lv        = LV_W'(fade_reg) + LV_W'(step_reg);
    assign is_fx     = (in_mode_reg == mfs_pkg::MODE_EFFECT);
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign vsel_fade   = is_fx ? mfs_pkg::Q20_ONE : fade_reg;
    assign vsel_vol    = is_fx ? in_vol_reg : cur_vol_reg;
    assign vsel_gain   = is_fx ? effect_gain : music_gain;
    assign emit_handle = is_fx ? in_handle_reg : cur_track_reg;

    mfs_vol #(
        .VOLUME_FULL (VOLUME_FULL)
    ) u_vol (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.vol_start),
        .fade    (vsel_fade),
        .vol     (vsel_vol),
        .gain    (vsel_gain),
        .done    (vol_done),
        .result  (vol_result)
    );

    always_comb begin
        cur_valid_next  = cur_valid_reg;
        cur_track_next  = cur_track_reg;
        cur_vol_next    = cur_vol_reg;
        pend_valid_next = pend_valid_reg;
        pend_track_next = pend_track_reg;
        pend_vol_next   = pend_vol_reg;
        fade_next       = fade_reg;
        phase_next      = phase_reg;
        case (cmd.st_op)
            mfs_pkg::ST_PEND_OUT: begin
                pend_valid_next = 1'b1;
                pend_track_next = in_handle_reg;
                pend_vol_next   = in_vol_reg;
                phase_next      = mfs_pkg::PH_OUT;
            end
            mfs_pkg::ST_LOAD: begin
                cur_valid_next  = 1'b1;
                cur_track_next  = in_handle_reg;
                cur_vol_next    = in_vol_reg;
                pend_valid_next = 1'b0;
                fade_next       = use_fade ? '0 : mfs_pkg::Q20_ONE;
                phase_next      = use_fade ? mfs_pkg::PH_IN : mfs_pkg::PH_NONE;
            end
            mfs_pkg::ST_STOP_FADE: begin
                pend_valid_next = 1'b0;
                phase_next      = mfs_pkg::PH_OUT;
            end
            mfs_pkg::ST_STOP_NOW: begin
                cur_valid_next  = 1'b0;
                cur_vol_next    = '0;
                pend_valid_next = 1'b0;
                fade_next       = '0;
                phase_next      = mfs_pkg::PH_NONE;
            end
            mfs_pkg::ST_TICK: begin
                if (phase_reg == mfs_pkg::PH_IN) begin
                    if (lv >= LV_W'(mfs_pkg::Q20_ONE)) begin
                        fade_next  = mfs_pkg::Q20_ONE;
                        phase_next = mfs_pkg::PH_NONE;
                    end else begin
                        fade_next = lv[mfs_pkg::FADE_W-1:0];
                    end
                end else if (phase_reg == mfs_pkg::PH_OUT) begin
                    if (tick_end) begin
                        fade_next  = '0;
                        phase_next = mfs_pkg::PH_NONE;
                    end else begin
                        fade_next = fade_reg - step_reg[mfs_pkg::FADE_W-1:0];
                    end
                end
            end
            mfs_pkg::ST_END: begin
                cur_valid_next = 1'b0;
                cur_vol_next   = '0;
            end
            mfs_pkg::ST_SWAP: begin
                cur_valid_next  = 1'b1;
                cur_track_next  = pend_track_reg;
                cur_vol_next    = pend_vol_reg;
                pend_valid_next = 1'b0;
                phase_next      = mfs_pkg::PH_IN;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg  <= 1'b0;
            cur_track_reg  <= '0;
            cur_vol_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_track_reg <= '0;
            pend_vol_reg   <= '0;
            fade_reg       <= '0;
            phase_reg      <= mfs_pkg::PH_NONE;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_valid_reg  <= cur_valid_next;
            cur_track_reg  <= cur_track_next;
            cur_vol_reg    <= cur_vol_next;
            pend_valid_reg <= pend_valid_next;
            pend_track_reg <= pend_track_next;
            pend_vol_reg   <= pend_vol_next;
            fade_reg       <= fade_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_mode_reg     <= mfs_pkg::mode_t'(s_axis_tuser);
            in_handle_reg   <= s_axis_tdata[15:0];
            in_vol_reg      <= s_axis_tdata[32:16];
            in_fade_req_reg <= s_axis_tdata[33];
            in_allows_reg   <= s_axis_tdata[34];
            step_reg        <= step_next;
        end
        if (cmd.emit) begin
            out_cmd_reg    <= cmd.emit_cmd;
            out_handle_reg <= emit_handle;
            out_volume_reg <= (cmd.emit_cmd == mfs_pkg::CMD_SETVOL) ? vol_result : '0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_comb begin
        stat.mode       = in_mode_reg;
        stat.cur_valid  = cur_valid_reg;
        stat.pend_valid = pend_valid_reg;
        stat.same_track = (in_handle_reg == cur_track_reg);
        stat.phase      = phase_reg;
        stat.use_fade   = use_fade;
        stat.fade_req   = in_fade_req_reg;
        stat.tick_end   = tick_end;
        stat.vol_done   = vol_done;
        stat.out_free   = out_free;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_volume_reg, out_handle_reg};
    assign m_axis_tuser  = out_cmd_reg;
    assign m_axis_tlast  = out_last_reg;

    a_fade_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fade_reg <= mfs_pkg::Q20_ONE)
        else $error("fade level above unity");

    a_fade_out_needs_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mfs_pkg::PH_OUT) |-> cur_valid_reg)
        else $error("fade-out with no current track");

endmodule

// File: rtl/mfs_ctrl.sv
module mfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  mfs_pkg::dp_stat_t   stat,
    output mfs_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_STOP_SW,
        S_LOAD,
        S_VOL_GO,
        S_VOL_WAIT,
        S_SETVOL,
        S_LOOP,
        S_ONCE,
        S_STOP_USER,
        S_STOP_END,
        S_SWAP
    } state_t;

    typedef enum logic [1:0] {
        AFT_NONE,
        AFT_LOOP,
        AFT_ONCE,
        AFT_STOP_END
    } after_t;

    state_t state_reg, state_next;
    after_t after_reg, after_next;

    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        cmd        = '0;
        cmd.st_op    = mfs_pkg::ST_NONE;
        cmd.emit_cmd = mfs_pkg::CMD_SETVOL;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.mode)
                    mfs_pkg::MODE_PLAY: begin
                        if (stat.cur_valid && stat.same_track &&
                            stat.phase != mfs_pkg::PH_OUT) begin
                            state_next = S_IDLE;
                        end else if (stat.cur_valid && stat.use_fade) begin
                            cmd.st_op  = mfs_pkg::ST_PEND_OUT;
                            state_next = S_IDLE;
                        end else if (stat.cur_valid) begin
                            state_next = S_STOP_SW;
                        end else begin
                            state_next = S_LOAD;
                        end
                    end
                    mfs_pkg::MODE_STOP: begin
                        if (!stat.cur_valid) begin
                            state_next = S_IDLE;
                        end else if (stat.fade_req) begin
                            cmd.st_op  = mfs_pkg::ST_STOP_FADE;
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_STOP_USER;
                        end
                    end
                    mfs_pkg::MODE_TICK: begin
                        state_next = (stat.phase == mfs_pkg::PH_NONE) ? S_IDLE : S_TICK;
                    end
                    default: begin
                        after_next = AFT_ONCE;
                        state_next = S_VOL_GO;
                    end
                endcase
            end
            S_TICK: begin
                cmd.st_op = mfs_pkg::ST_TICK;
                if (stat.phase == mfs_pkg::PH_OUT && stat.tick_end) begin
                    if (stat.cur_valid) begin
                        after_next = AFT_STOP_END;
                        state_next = S_VOL_GO;
                    end else if (stat.pend_valid) begin
                        state_next = S_SWAP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (stat.cur_valid) begin
                    after_next = AFT_NONE;
                    state_next = S_VOL_GO;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_STOP_SW: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_cmd = mfs_pkg::CMD_STOP;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.st_op  = mfs_pkg::ST_LOAD;
                after_next = AFT_LOOP;
                state_next = S_VOL_GO;
            end
            S_VOL_GO: begin
                cmd.vol_start = 1'b1;
                state_next    = S_VOL_WAIT;
            end
            S_VOL_WAIT: begin
                if (stat.vol_done) begin
                    state_next = S_SETVOL;
                end
            end
            S_SETVOL: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_cmd  = mfs_pkg::CMD_SETVOL;
                    cmd.emit_last = (after_reg == AFT_NONE);
                    case (after_reg)
                        AFT_LOOP:     state_next = S_LOOP;
                        AFT_ONCE:     state_next = S_ONCE;
                        AFT_STOP_END: state_next = S_STOP_END;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOP: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_cmd  = mfs_pkg::CMD_LOOP;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ONCE: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_cmd  = mfs_pkg::CMD_ONCE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_STOP_USER: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_cmd  = mfs_pkg::CMD_STOP;
                    cmd.emit_last = 1'b1;
                    cmd.st_op     = mfs_pkg::ST_STOP_NOW;
                    state_next    = S_IDLE;
                end
            end
            S_STOP_END: begin
                // stop the faded track, then start the queued one if any
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_cmd  = mfs_pkg::CMD_STOP;
                    cmd.emit_last = !stat.pend_valid;
                    cmd.st_op     = mfs_pkg::ST_END;
                    state_next    = stat.pend_valid ? S_SWAP : S_IDLE;
                end
            end
            S_SWAP: begin
                cmd.st_op  = mfs_pkg::ST_SWAP;
                after_next = AFT_LOOP;
                state_next = S_VOL_GO;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            after_reg <= AFT_NONE;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over an untaken one");

    a_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.vol_done |-> (state_reg == S_VOL_WAIT))
        else $error("volume result arrived outside the wait state");

endmodule

// File: rtl/music_fade_switch_sequencer.sv
// Channel   Dir  Signals                     Contents
// requests  in   s_axis_t{valid,ready,data,  tuser: mode; tdata: handle, volume,
//                user}                       fade flags, elapsed ms
// results   out  m_axis_t{valid,ready,data,  tuser: command; tdata: handle,
//                user,last}                  volume; tlast: last of run
// config    in   APB psel..prdata            fade_rate, music_gain, effect_gain
//
// A request that causes no result holds the block only for its idle and decode
// states; a fade-out that ends and starts the queued track holds it longest; each
// engine volume passes the four-stage multiplier chain before its result is sent.
// Reset (aresetn low, synchronous) clears playback state and the result register.
// A stalled result channel holds the controller before its next result only.
module music_fade_switch_sequencer #(
    parameter int unsigned VOLUME_FULL = 255
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] track_handle, [32:16] source_volume, [33] fade_requested,
    // [34] track_allows_fade, [50:35] elapsed_ms, [55:51] zero
    input  logic [mfs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] target_handle, [23:16] volume
    output logic [mfs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] command
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfs_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [mfs_pkg::FADE_W-1:0] fade_rate_reg;
    logic [mfs_pkg::QVOL_W-1:0] music_gain_reg;
    logic [mfs_pkg::QVOL_W-1:0] effect_gain_reg;
    logic                       cfg_wr;
    logic [1:0]                 reg_idx;

    mfs_pkg::ctl_cmd_t cmd;
    mfs_pkg::dp_stat_t stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_rate_reg   <= mfs_pkg::FADE_RATE_RST;
            music_gain_reg  <= mfs_pkg::MUSIC_GAIN_RST;
            effect_gain_reg <= mfs_pkg::EFFECT_GAIN_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mfs_pkg::REG_FADE_RATE:   fade_rate_reg   <= pwdata[mfs_pkg::FADE_W-1:0];
                mfs_pkg::REG_MUSIC_GAIN:  music_gain_reg  <= pwdata[mfs_pkg::QVOL_W-1:0];
                mfs_pkg::REG_EFFECT_GAIN: effect_gain_reg <= pwdata[mfs_pkg::QVOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mfs_pkg::REG_FADE_RATE:   prdata = 32'(fade_rate_reg);
            mfs_pkg::REG_MUSIC_GAIN:  prdata = 32'(music_gain_reg);
            mfs_pkg::REG_EFFECT_GAIN: prdata = 32'(effect_gain_reg);
            default:                  prdata = '0;
        endcase
    end

    mfs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    mfs_dp #(
        .VOLUME_FULL (VOLUME_FULL)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fade_rate     (fade_rate_reg),
        .music_gain    (music_gain_reg),
        .effect_gain   (effect_gain_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
